FILE: design/ncrp_pkg.sv
// ----------------------------------------------------------------------------
// ncrp_pkg
// Shared types and constants for the name and count record parser.
// ----------------------------------------------------------------------------
package ncrp_pkg;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_LONG        = 3'd0,
    ERR_EMPTY_NAME  = 3'd1,
    ERR_EMPTY_COUNT = 3'd2,
    ERR_OVERFLOW    = 3'd3,
    ERR_NO_COMMA    = 3'd4
  } err_t;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int COUNT_W = 64;
  localparam int LEN_W   = 6;

endpackage

FILE: design/ncrp_in_if.sv
// ----------------------------------------------------------------------------
// ncrp_in_if
// Byte channel into the record parser: one line byte per beat.
// ----------------------------------------------------------------------------
interface ncrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_start;
  logic       line_end;

  modport source (output valid, output char_in, output line_start, output line_end,
                  input ready);
  modport sink   (input valid, input char_in, input line_start, input line_end,
                  output ready);
endinterface

FILE: design/ncrp_out_if.sv
// ----------------------------------------------------------------------------
// ncrp_out_if
// Result channel of the record parser: echo, record or error per beat.
// ----------------------------------------------------------------------------
interface ncrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_byte;
  logic [63:0] count_value;
  logic [5:0]  name_length;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output name_byte, output count_value,
                  output name_length, output error_code, input ready);
  modport sink   (input valid, input kind, input name_byte, input count_value,
                  input name_length, input error_code, output ready);
endinterface

FILE: design/name_count_record_parser_core.sv
// ----------------------------------------------------------------------------
// name_count_record_parser_core
// Parses "name,count" record lines one byte per beat, echoing name bytes and
// reporting the decimal count, the name length or an error code.
// ----------------------------------------------------------------------------
// Takes one byte per clock and gives its result from a result register:
// the byte is captured in an input register, then the parse step (a few byte
// compares and a 68-bit shift-add for count*10+digit with carry-out overflow
// check) runs between that register and the result register. Throughput is
// one byte per cycle while the result side takes its beats; a pending result
// stalls the input only when the result register is still occupied. Names
// hold 1 to NAME_LIMIT-1 bytes; name_length carries the low 6 bits of the
// name byte count.
module name_count_record_parser_core
  import ncrp_pkg::*;
#(
  parameter int NAME_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ncrp_in_if.sink     in_if,
  ncrp_out_if.source  out_if
);

  localparam int CW = $clog2(NAME_LIMIT);
  localparam logic [CW-1:0] NAME_MAX = CW'(NAME_LIMIT - 1);

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_COUNT = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  // input stage
  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_start_r;
  logic        s1_end_r;
  logic        s1_adv;

  // parse state
  phase_t              phase_r, phase_nxt, ph_cur;
  logic [CW-1:0]       name_count_r, name_count_nxt, cnt_cur;
  logic [COUNT_W-1:0]  count_accum_r, count_accum_nxt, acc_cur;
  logic                digit_seen_r, digit_seen_nxt, dig_cur;

  // result stage
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [7:0]          out_byte_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [LEN_W-1:0]    out_len_r;
  err_t                out_err_r;

  logic                res_valid;
  kind_t               res_kind;
  logic [7:0]          res_byte;
  logic [COUNT_W-1:0]  res_count;
  logic [LEN_W-1:0]    res_len;
  err_t                res_err;

  logic                is_digit;
  logic [COUNT_W+3:0]  acc_mul;
  logic                acc_ovf;
  logic [8:0]          len_ext;

  assign s1_adv      = s1_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_if.valid && in_if.ready) begin
      s1_char_r  <= in_if.char_in;
      s1_start_r <= in_if.line_start;
      s1_end_r   <= in_if.line_end;
    end
  end

  // line start clears the parse before this byte
  assign ph_cur  = s1_start_r ? PH_NAME : phase_r;
  assign cnt_cur = s1_start_r ? '0 : name_count_r;
  assign acc_cur = s1_start_r ? '0 : count_accum_r;
  assign dig_cur = s1_start_r ? 1'b0 : digit_seen_r;

  assign is_digit = (s1_char_r >= CHAR_ZERO) && (s1_char_r <= CHAR_NINE);
  assign acc_mul  = ({4'b0, acc_cur} << 3) + ({4'b0, acc_cur} << 1)
                  + (COUNT_W+4)'(s1_char_r[3:0]);
  assign acc_ovf  = |acc_mul[COUNT_W+3:COUNT_W];
  assign len_ext  = 9'(cnt_cur);

  always_comb begin
    phase_nxt       = ph_cur;
    name_count_nxt  = cnt_cur;
    count_accum_nxt = acc_cur;
    digit_seen_nxt  = dig_cur;
    res_valid       = 1'b0;
    res_kind        = KIND_ECHO;
    res_byte        = '0;
    res_count       = '0;
    res_len         = '0;
    res_err         = ERR_LONG;
    unique case (ph_cur)
      PH_NAME: begin
        if (s1_char_r == CHAR_COMMA) begin
          if (cnt_cur == '0) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERR;
            res_err   = ERR_EMPTY_NAME;
            phase_nxt = PH_DONE;
          end else if (s1_end_r) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERR;
            res_err   = ERR_EMPTY_COUNT;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_COUNT;
          end
        end else if (cnt_cur >= NAME_MAX) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERR;
          res_err   = ERR_LONG;
          phase_nxt = PH_DONE;
        end else if (s1_end_r) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERR;
          res_err   = ERR_NO_COMMA;
          phase_nxt = PH_DONE;
        end else begin
          name_count_nxt = cnt_cur + CW'(1);
          res_valid      = 1'b1;
          res_kind       = KIND_ECHO;
          res_byte       = s1_char_r;
        end
      end
      PH_COUNT: begin
        if (is_digit) begin
          if (acc_ovf) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERR;
            res_err   = ERR_OVERFLOW;
            phase_nxt = PH_DONE;
          end else begin
            count_accum_nxt = acc_mul[COUNT_W-1:0];
            digit_seen_nxt  = 1'b1;
            if (s1_end_r) begin
              res_valid = 1'b1;
              res_kind  = KIND_DONE;
              res_count = acc_mul[COUNT_W-1:0];
              res_len   = len_ext[LEN_W-1:0];
              phase_nxt = PH_DONE;
            end
          end
        end else if (!dig_cur) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERR;
          res_err   = ERR_EMPTY_COUNT;
          phase_nxt = PH_DONE;
        end else begin
          res_valid = 1'b1;
          res_kind  = KIND_DONE;
          res_count = acc_cur;
          res_len   = len_ext[LEN_W-1:0];
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        // done: ignore until next line start
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_NAME;
      name_count_r  <= '0;
      count_accum_r <= '0;
      digit_seen_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase_r       <= phase_nxt;
        name_count_r  <= name_count_nxt;
        count_accum_r <= count_accum_nxt;
        digit_seen_r  <= digit_seen_nxt;
        out_valid_r   <= res_valid;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_count_r <= res_count;
      out_len_r   <= res_len;
      out_err_r   <= res_err;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.name_byte   = out_byte_r;
  assign out_if.count_value = out_count_r;
  assign out_if.name_length = out_len_r;
  assign out_if.error_code  = out_err_r;

`ifndef NO_ASSERTIONS
  a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_valid && res_kind != KIND_ECHO) |=> (phase_r == PH_DONE))
    else $error("parse state not closed after record or error beat");

  a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
    name_count_r <= NAME_MAX)
    else $error("name byte count beyond limit");

  a_no_digit_in_name: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAME) |-> !digit_seen_r)
    else $error("digit flag set during name field");

  a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ECHO) |-> (out_count_r == '0 && out_len_r == '0))
    else $error("echo beat carries record fields");
`endif

endmodule
